// ===== design/ipcs_pkg.sv =====
// ipcs_pkg: shared types and constants for the ipv4/udp checksum generator
// holds the front-to-back queue entry, the result record and packet offsets
// no dependencies
`timescale 1ns / 1ps

package ipcs_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int UDP_ADD_W = 18;   // four 16-bit words summed at the length byte
   localparam int HDR_ACC_W = 21;   // at most 30 header words
   localparam int UDP_ACC_W = 32;

   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [7:0]  UDP_PROTOCOL  = 8'd17;
   localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;

   // byte positions inside the ipv4 header
   localparam logic [15:0] IDX_VER_IHL   = 16'd0;
   localparam logic [15:0] IDX_PROTOCOL  = 16'd9;
   localparam logic [15:0] IDX_HCK_HI    = 16'd10;
   localparam logic [15:0] IDX_HCK_LO    = 16'd11;
   localparam logic [15:0] IDX_ADDR_FIRST = 16'd12;
   localparam logic [15:0] IDX_ADDR_LAST  = 16'd19;

   // byte offsets inside the udp header
   localparam logic [15:0] OFF_LEN_HI = 16'd4;
   localparam logic [15:0] OFF_LEN_LO = 16'd5;
   localparam logic [15:0] OFF_DATA   = 16'd8;

   typedef struct packed {
      logic [15:0]          hdr_add;
      logic [UDP_ADD_W-1:0] udp_add;
      logic                 last;
      logic                 udp_ok;
      logic                 bad;
   } ipcs_entry_type;

   typedef struct packed {
      logic [15:0] header_checksum;
      logic [15:0] udp_checksum;
      logic        is_udp;
      logic        malformed;
   } ipcs_result_type;

endpackage

// ===== design/ipcs_front.sv =====
// ipcs_front: per-byte packet parser, tracks header length, protocol and udp length
// turns each byte into checksum addends and end-of-packet verdicts; uses ipcs_pkg
`timescale 1ns / 1ps

module ipcs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   input  logic                    q_full,
   output logic                    q_push,
   output ipcs_pkg::ipcs_entry_type q_entry
);
   import ipcs_pkg::*;

   logic [15:0]     cnt_ff, cnt_in;
   logic [5:0]      hb_ff, hb_in;
   logic [7:0]      proto_ff, proto_in;
   logic [15:0]     len_ff, len_in;
   logic            known_ff, known_in;
   logic [7:0]      hi_ff, hi_in;
   logic [0:3][7:0] port_ff, port_in;

   logic            active;
   logic [5:0]      hb_now;
   logic [7:0]      proto_now;
   logic [15:0]     v;
   logic            udp_seg;
   logic [15:0]     off;
   logic [15:0]     len_new;
   logic [15:0]     w0, w1, w2;
   logic [17:0]     len_sum;
   logic            take_len;
   logic [15:0]     len_now;
   logic            known_now;
   logic [15:0]     n;
   logic            bad_hdr;
   logic            udp_short;
   logic            is_udp_proto;

   assign q_push = req_push && !q_full;

   always_comb begin
      active    = cnt_ff != COUNT_MAX;
      hb_now    = (cnt_ff == IDX_VER_IHL) ? {req_data_byte[3:0], 2'b00} : hb_ff;
      proto_now = (active && cnt_ff == IDX_PROTOCOL) ? req_data_byte : proto_ff;
      v         = cnt_ff[0] ? {8'h00, req_data_byte} : {req_data_byte, 8'h00};
      udp_seg   = active && proto_now == UDP_PROTOCOL && hb_now >= MIN_HDR_BYTES &&
                  cnt_ff >= {10'b0, hb_now};
      off       = cnt_ff - {10'b0, hb_now};
      take_len  = udp_seg && off == OFF_LEN_LO;
      len_new   = {hi_ff, req_data_byte};
      // port words and length bytes only count where they lie inside the udp length
      w0 = {port_ff[0] & {8{len_new != 16'd0}}, port_ff[1] & {8{len_new > 16'd1}}};
      w1 = {port_ff[2] & {8{len_new > 16'd2}}, port_ff[3] & {8{len_new > 16'd3}}};
      w2 = {hi_ff & {8{len_new > 16'd4}}, req_data_byte & {8{len_new > 16'd5}}};
      len_sum = {2'b0, w0} + {2'b0, w1} + {2'b0, w2} + {2'b0, len_new};

      len_now   = take_len ? len_new : len_ff;
      known_now = take_len || known_ff;
      n         = active ? cnt_ff + 16'd1 : cnt_ff;
      is_udp_proto = proto_now == UDP_PROTOCOL;
      bad_hdr   = hb_now < MIN_HDR_BYTES || n < {10'b0, hb_now};
      udp_short = !known_now ||
                  {1'b0, n} < ({11'b0, hb_now} + {1'b0, len_now});

      q_entry.hdr_add = (active && cnt_ff < {10'b0, hb_now} && cnt_ff != IDX_HCK_HI &&
                         cnt_ff != IDX_HCK_LO) ? v : 16'h0000;
      if (active && cnt_ff >= IDX_ADDR_FIRST && cnt_ff <= IDX_ADDR_LAST) begin
         q_entry.udp_add = {2'b0, v};
      end else if (take_len) begin
         q_entry.udp_add = len_sum;
      end else if (udp_seg && off >= OFF_DATA && known_ff && off < len_ff) begin
         q_entry.udp_add = {2'b0, v};
      end else begin
         q_entry.udp_add = '0;
      end
      q_entry.last   = req_last_byte;
      q_entry.udp_ok = !bad_hdr && is_udp_proto && !udp_short;
      q_entry.bad    = bad_hdr || (is_udp_proto && udp_short);

      cnt_in   = cnt_ff;
      hb_in    = hb_ff;
      proto_in = proto_ff;
      len_in   = len_ff;
      known_in = known_ff;
      hi_in    = hi_ff;
      port_in  = port_ff;
      if (q_push) begin
         if (req_last_byte) begin
            cnt_in   = '0;
            hb_in    = '0;
            proto_in = '0;
            len_in   = '0;
            known_in = 1'b0;
            hi_in    = '0;
            port_in  = '0;
         end else if (active) begin
            cnt_in   = cnt_ff + 16'd1;
            hb_in    = hb_now;
            proto_in = proto_now;
            if (udp_seg && off < OFF_LEN_HI) begin
               port_in[off[1:0]] = req_data_byte;
            end
            if (udp_seg && off == OFF_LEN_HI) begin
               hi_in = req_data_byte;
            end
            if (take_len) begin
               len_in   = len_new;
               known_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         hb_ff    <= '0;
         proto_ff <= '0;
         len_ff   <= '0;
         known_ff <= 1'b0;
         hi_ff    <= '0;
         port_ff  <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         hb_ff    <= hb_in;
         proto_ff <= proto_in;
         len_ff   <= len_in;
         known_ff <= known_in;
         hi_ff    <= hi_in;
         port_ff  <= port_in;
      end
   end

endmodule

// ===== design/ipcs_queue.sv =====
// ipcs_queue: short flop-based queue of parsed beats between front and back
// uses ipcs_pkg for the entry type and depth
`timescale 1ns / 1ps

module ipcs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ipcs_pkg::ipcs_entry_type din,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output ipcs_pkg::ipcs_entry_type dout
);
   import ipcs_pkg::*;

   ipcs_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_pop;

   assign full   = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty  = cnt_ff == '0;
   assign dout   = mem_ff[rd_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== design/ipcs_back.sv =====
// ipcs_back: checksum accumulators, end-around-carry fold and result queue
// consumes parsed beats from ipcs_queue; uses ipcs_pkg
`timescale 1ns / 1ps

module ipcs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  ipcs_pkg::ipcs_entry_type q_entry,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [15:0]             rsp_header_checksum,
   output logic [15:0]             rsp_udp_checksum,
   output logic                    rsp_is_udp,
   output logic                    rsp_malformed
);
   import ipcs_pkg::*;

   // two folds bring any 32-bit total back to a 16-bit one's complement sum
   function automatic logic [15:0] fold(input logic [UDP_ACC_W-1:0] t);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, t[31:16]} + {1'b0, t[15:0]};
      s2 = {1'b0, s1[15:0]} + {16'b0, s1[16]};
      return s2[15:0];
   endfunction

   logic [HDR_ACC_W-1:0] hacc_ff, hacc_in;
   logic [UDP_ACC_W-1:0] uacc_ff, uacc_in;
   logic                 fin_valid_ff, fin_valid_in;
   logic [HDR_ACC_W-1:0] fin_h_ff, fin_h_in;
   logic [UDP_ACC_W-1:0] fin_u_ff, fin_u_in;
   logic                 fin_ok_ff, fin_ok_in;
   logic                 fin_bad_ff, fin_bad_in;

   ipcs_result_type      out_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    out_wr_ff, out_wr_in;
   logic [QPTR_W-1:0]    out_rd_ff, out_rd_in;
   logic [QCNT_W-1:0]    out_cnt_ff, out_cnt_in;

   logic [HDR_ACC_W-1:0] h_sum;
   logic [UDP_ACC_W-1:0] u_sum;
   logic [QCNT_W-1:0]    pending;
   logic                 room;
   logic                 out_pop;
   ipcs_result_type      fin_res;
   ipcs_result_type      head;

   always_comb begin
      // a packet end may only leave when its result has a slot reserved
      pending = out_cnt_ff + QCNT_W'(fin_valid_ff);
      room    = pending < QCNT_W'(QUEUE_DEPTH);
      q_pop   = !q_empty && (!q_entry.last || room);

      h_sum = hacc_ff + HDR_ACC_W'(q_entry.hdr_add);
      u_sum = uacc_ff + UDP_ACC_W'(q_entry.udp_add) +
              ((q_entry.last && q_entry.udp_ok) ? UDP_ACC_W'(UDP_PROTOCOL) : '0);

      hacc_in      = hacc_ff;
      uacc_in      = uacc_ff;
      fin_valid_in = q_pop && q_entry.last;
      fin_h_in     = fin_h_ff;
      fin_u_in     = fin_u_ff;
      fin_ok_in    = fin_ok_ff;
      fin_bad_in   = fin_bad_ff;
      if (q_pop) begin
         if (q_entry.last) begin
            hacc_in    = '0;
            uacc_in    = '0;
            fin_h_in   = h_sum;
            fin_u_in   = u_sum;
            fin_ok_in  = q_entry.udp_ok;
            fin_bad_in = q_entry.bad;
         end else begin
            hacc_in = h_sum;
            uacc_in = u_sum;
         end
      end

      fin_res.header_checksum = ~fold(UDP_ACC_W'(fin_h_ff));
      fin_res.udp_checksum    = fin_ok_ff ? ~fold(fin_u_ff) : 16'h0000;
      fin_res.is_udp          = fin_ok_ff;
      fin_res.malformed       = fin_bad_ff;

      out_pop    = rsp_pop && !rsp_empty;
      out_wr_in  = fin_valid_ff ? out_wr_ff + 1'b1 : out_wr_ff;
      out_rd_in  = out_pop ? out_rd_ff + 1'b1 : out_rd_ff;
      out_cnt_in = out_cnt_ff + QCNT_W'(fin_valid_ff) - QCNT_W'(out_pop);
   end

   assign rsp_empty           = out_cnt_ff == '0;
   assign head                = out_mem_ff[out_rd_ff];
   assign rsp_header_checksum = head.header_checksum;
   assign rsp_udp_checksum    = head.udp_checksum;
   assign rsp_is_udp          = head.is_udp;
   assign rsp_malformed       = head.malformed;

   always_ff @(posedge clock) begin
      fin_h_ff   <= fin_h_in;
      fin_u_ff   <= fin_u_in;
      fin_ok_ff  <= fin_ok_in;
      fin_bad_ff <= fin_bad_in;
      if (fin_valid_ff) begin
         out_mem_ff[out_wr_ff] <= fin_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hacc_ff      <= '0;
         uacc_ff      <= '0;
         fin_valid_ff <= 1'b0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_cnt_ff   <= '0;
      end else begin
         hacc_ff      <= hacc_in;
         uacc_ff      <= uacc_in;
         fin_valid_ff <= fin_valid_in;
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_cnt_ff   <= out_cnt_in;
      end
   end

endmodule

// ===== design/ipv4_udp_checksum_generator_unit.sv =====
// ipv4 header and udp checksum generator, one packet byte per beat
// throughput: one byte per cycle while req_full is low
// after the last byte is accepted, its beat passes the parsed-beat queue, the fin registers
// and the result queue before rsp_empty falls and the result can be popped
// one result per packet; a 4-deep parsed-beat queue and a 4-deep result queue decouple sides
// synchronous active-high reset empties both queues and clears the parser state and the accumulators
`timescale 1ns / 1ps

module ipv4_udp_checksum_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_header_checksum,
   output logic [15:0] rsp_udp_checksum,
   output logic        rsp_is_udp,
   output logic        rsp_malformed
);
   import ipcs_pkg::*;

   ipcs_entry_type front_entry;
   ipcs_entry_type back_entry;
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;

   assign req_full = q_full;

   ipcs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (front_entry)
   );

   ipcs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (front_entry),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .dout  (back_entry)
   );

   ipcs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_entry             (back_entry),
      .q_pop               (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_udp_checksum    (rsp_udp_checksum),
      .rsp_is_udp          (rsp_is_udp),
      .rsp_malformed       (rsp_malformed)
   );

endmodule

// ===== design/ipcs_checker.sv =====
// ipcs_checker: port-level checks on the checksum generator top level
// bound to ipv4_udp_checksum_generator_unit; no package dependency
`timescale 1ns / 1ps

module ipcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_header_checksum,
   input logic [15:0] rsp_udp_checksum,
   input logic        rsp_is_udp,
   input logic        rsp_malformed
);

   // reset leaves both sides empty
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a good udp result is never also malformed
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_is_udp && rsp_malformed))
      else $error("udp result flagged malformed");

   // non-udp results carry a zero udp checksum
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_is_udp) |-> rsp_udp_checksum == 16'h0000)
      else $error("udp checksum set on non-udp result");

   // a waiting result beat holds until popped
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_header_checksum) &&
      $stable(rsp_udp_checksum) && $stable(rsp_is_udp) && $stable(rsp_malformed))
      else $error("result beat changed while stalled");

endmodule

bind ipv4_udp_checksum_generator_unit ipcs_checker u_ipcs_checker (.*);
